FILE: design/thermal_roi_statistics_core_assert.svh
// Assertion macros for the thermal ROI statistics core.
// Each macro builds one clocked concurrent assertion with a synchronous
// active-low reset as the disable condition.
`ifndef THERMAL_ROI_STATISTICS_CORE_ASSERT_SVH
`define THERMAL_ROI_STATISTICS_CORE_ASSERT_SVH

// Implication in the same cycle.
`define TROI_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle.
`define TROI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/troi_pkg.sv
// ----------------------------------------------------------------------------
// troi_pkg
// Shared types and constants of the thermal ROI statistics core.
// ----------------------------------------------------------------------------
package troi_pkg;

    localparam int DEF_MAX_WIDTH = 4096;

    localparam logic signed [23:0] T_MAX      = 24'sh7FFFFF;
    localparam logic signed [23:0] T_MIN      = -24'sh800000;
    localparam int                 KELVIN_Q16 = 17901158;
    localparam logic [12:0]        ROW_CAP    = 13'd8191;

    // sample_format codes
    localparam logic [1:0] FMT_INT16 = 2'd0;
    localparam logic [1:0] FMT_FLOAT = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_FORMAT  = 3'd0;
    localparam logic [2:0] CFG_FWIDTH  = 3'd1;
    localparam logic [2:0] CFG_ISCALE  = 3'd2;
    localparam logic [2:0] CFG_KOFFSET = 3'd3;
    localparam logic [2:0] CFG_ROI_X   = 3'd4;
    localparam logic [2:0] CFG_ROI_Y   = 3'd5;
    localparam logic [2:0] CFG_ROI_W   = 3'd6;
    localparam logic [2:0] CFG_ROI_H   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CONV,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic conv;
        logic acc;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: design/thermal_roi_statistics_core.sv
// ----------------------------------------------------------------------------
// thermal_roi_statistics_core
// Each pixel beat passes through the sequencer states multiply, convert,
// accumulate and output load before its result beat; a frame-end pixel also
// waits for the bit-serial 48-bit mean divider. A new pixel is taken only once the last one is done.
// Reset: synchronous active low; loads default configuration and clears
// positions and statistics.
// ----------------------------------------------------------------------------
module thermal_roi_statistics_core #(
    parameter int MAX_WIDTH = troi_pkg::DEF_MAX_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // raw_word
    input  logic         s_axis_tlast,   // last_in_frame
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // temperature, roi_max, roi_min, roi_average, roi_count, zero pad
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast    // frame_done
);
    import troi_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    troi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    troi_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_word      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule

FILE: design/troi_div.sv
// ----------------------------------------------------------------------------
// troi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module troi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [24:0] i_divisor,
    output logic        o_done,
    output logic [47:0] o_quotient
);
    localparam int DIV_STEPS = 48;
    localparam int SW        = $clog2(DIV_STEPS + 1);

    logic [SW-1:0] r_steps;
    logic          r_busy;
    logic          r_done;
    logic [47:0]   r_quo;
    logic [24:0]   r_rem;
    logic [24:0]   r_dvs;
    logic [25:0]   w_trial;
    logic          w_fit;

    assign w_trial = {r_rem, r_quo[47]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= SW'(DIV_STEPS);
            end else if (r_busy) begin
                r_steps <= r_steps - SW'(1);
                if (r_steps == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[46:0], w_fit};
            // remainder stays below the divisor, so 25 bits hold it
            r_rem <= w_fit ? 25'(w_trial - {1'b0, r_dvs}) : w_trial[24:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

FILE: design/troi_dp.sv
// ----------------------------------------------------------------------------
// troi_dp
// Datapath: configuration, pixel conversion, position tracking, region
// statistics, mean divider and output register.
// ----------------------------------------------------------------------------
module troi_dp #(
    parameter int MAX_WIDTH = troi_pkg::DEF_MAX_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [23:0]      i_cfg_data,
    input  logic [31:0]      i_word,
    input  logic             i_last,
    input  troi_pkg::t_dp_cmd i_cmd,
    output troi_pkg::t_dp_sts o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [127:0]     o_out_data,
    output logic             o_out_last
);
    import troi_pkg::*;

    localparam int          CW   = $clog2(MAX_WIDTH);
    localparam logic [14:0] MAXW = 15'(MAX_WIDTH);

    // configuration
    logic [1:0]         r_fmt;
    logic [12:0]        r_fw;
    logic [23:0]        r_isc;
    logic signed [23:0] r_koff;
    logic signed [12:0] r_rx;
    logic signed [12:0] r_ry;
    logic [13:0]        r_rw;
    logic [13:0]        r_rh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_INT16;
            r_fw   <= 13'd640;
            r_isc  <= 24'd65536;
            r_koff <= '0;
            r_rx   <= '0;
            r_ry   <= '0;
            r_rw   <= 14'd8192;
            r_rh   <= 14'd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FORMAT:  r_fmt  <= i_cfg_data[1:0];
                CFG_FWIDTH:  r_fw   <= i_cfg_data[12:0];
                CFG_ISCALE:  r_isc  <= i_cfg_data;
                CFG_KOFFSET: r_koff <= $signed(i_cfg_data);
                CFG_ROI_X:   r_rx   <= $signed(i_cfg_data[12:0]);
                CFG_ROI_Y:   r_ry   <= $signed(i_cfg_data[12:0]);
                CFG_ROI_W:   r_rw   <= i_cfg_data[13:0];
                CFG_ROI_H:   r_rh   <= i_cfg_data[13:0];
                default:     ;
            endcase
        end
    end

    // positions and region test
    logic [CW-1:0]      r_col;
    logic [12:0]        r_row;
    logic [14:0]        w_weff;
    logic [14:0]        w_colx;
    logic signed [16:0] w_xs, w_xe, w_xe_raw, w_ys, w_ye, w_c, w_r;
    logic               w_inside;

    always_comb begin
        if (r_fw == 13'd0)            w_weff = 15'd1;
        else if ({2'b0, r_fw} > MAXW) w_weff = MAXW;
        else                          w_weff = {2'b0, r_fw};
        w_colx   = 15'(r_col);
        w_xs     = r_rx[12] ? 17'sd0 : 17'(r_rx);
        w_xe_raw = 17'(r_rx) + $signed({3'b0, r_rw});
        w_xe     = (w_xe_raw > $signed({2'b0, w_weff})) ? $signed({2'b0, w_weff}) : w_xe_raw;
        w_ys     = r_ry[12] ? 17'sd0 : 17'(r_ry);
        w_ye     = 17'(r_ry) + $signed({3'b0, r_rh});
        w_c      = $signed({2'b0, w_colx});
        w_r      = $signed({4'b0, r_row});
        w_inside = (w_c >= w_xs) && (w_c < w_xe) && (w_r >= w_ys) && (w_r < w_ye);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load_in) begin
            if (i_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_colx + 15'd1 >= w_weff) begin
                r_col <= '0;
                if (r_row < ROW_CAP) r_row <= r_row + 13'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // conversion
    function automatic logic signed [23:0] f_float(input logic [31:0] w);
        logic        neg;
        logic [7:0]  ex;
        logic [24:0] man;
        logic [4:0]  r;
        logic [25:0] rnd;
        logic [24:0] mag;
        logic signed [23:0] res;
        neg = w[31];
        ex  = w[30:23];
        man = {2'b01, w[22:0]};
        r   = 5'(8'd142 - ex);
        rnd = 26'(man) + (26'd1 << (r - 5'd1));
        mag = 25'(rnd >> r);
        if (ex == 8'hFF)
            res = (w[22:0] != 23'd0) ? 24'sd0 : (neg ? T_MIN : T_MAX);
        else if (ex == 8'd0 || ex < 8'd117)
            res = 24'sd0;
        else if (ex >= 8'd142)
            res = neg ? T_MIN : T_MAX;
        else if (neg)
            res = 24'(-$signed({1'b0, mag}));
        else
            res = mag[23] ? T_MAX : $signed(mag[23:0]);
        return res;
    endfunction

    logic [31:0]        r_word;
    logic               r_last;
    logic               r_inside;
    logic signed [40:0] r_prod;
    logic signed [23:0] r_ftemp;
    logic signed [23:0] r_temp;
    logic               r_valid;
    logic signed [40:0] w_prod;
    logic signed [41:0] w_acc;
    logic signed [41:0] w_shr;
    logic signed [23:0] w_itemp;

    assign w_prod = $signed(r_word[15:0]) * $signed({1'b0, r_isc});

    always_comb begin
        w_acc = 42'(r_prod) + (42'(r_koff) <<< 8) - 42'sd17901158 + 42'sd128;
        w_shr = w_acc >>> 8;
        if (w_shr > 42'(T_MAX))      w_itemp = T_MAX;
        else if (w_shr < 42'(T_MIN)) w_itemp = T_MIN;
        else                         w_itemp = w_shr[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_word   <= i_word;
            r_last   <= i_last;
            r_inside <= w_inside;
        end
        if (i_cmd.mul) begin
            r_prod  <= w_prod;
            r_ftemp <= f_float(r_word);
        end
        if (i_cmd.conv) begin
            r_valid <= (r_fmt == FMT_INT16) || (r_fmt == FMT_FLOAT);
            case (r_fmt)
                FMT_INT16: r_temp <= w_itemp;
                FMT_FLOAT: r_temp <= r_ftemp;
                default:   r_temp <= '0;
            endcase
        end
    end

    // statistics
    logic signed [23:0] r_max, r_min;
    logic signed [47:0] r_sum;
    logic [24:0]        r_cnt;
    logic               w_upd;
    logic               w_clear;

    assign w_upd   = i_cmd.acc && r_valid && r_inside && !r_cnt[24];
    assign w_clear = i_cmd.load_out && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_max <= T_MIN;
            r_min <= T_MAX;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (w_upd) begin
            if (r_temp > r_max) r_max <= r_temp;
            if (r_temp < r_min) r_min <= r_temp;
            r_sum <= r_sum + 48'(r_temp);
            r_cnt <= r_cnt + 25'd1;
        end
    end

    // mean
    logic               r_div_start;
    logic               w_div_done;
    logic [47:0]        w_quo;
    logic [47:0]        w_abs_sum;
    logic signed [25:0] w_avg_full;
    logic signed [23:0] w_avg;

    // start in the cycle after div_start so the frame-end pixel is already in sum and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div_start <= 1'b0;
        else          r_div_start <= i_cmd.div_start;
    end

    assign w_abs_sum = r_sum[47] ? 48'(-r_sum) : r_sum;

    troi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_abs_sum),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        w_avg_full = r_sum[47] ? -$signed({1'b0, w_quo[24:0]}) : $signed({1'b0, w_quo[24:0]});
        if (r_cnt == 25'd0)               w_avg = '0;
        else if (w_avg_full > 26'(T_MAX)) w_avg = T_MAX;
        else if (w_avg_full < 26'(T_MIN)) w_avg = T_MIN;
        else                              w_avg = w_avg_full[23:0];
    end

    // output register
    logic         r_ovalid;
    logic [127:0] r_odata;
    logic         r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_olast <= r_last;
            if (r_last)
                r_odata <= {7'd0, r_cnt, w_avg, r_min, r_max, r_temp};
            else
                r_odata <= {104'd0, r_temp};
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_ovalid && !i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;
    assign o_out_last     = r_olast;
endmodule

FILE: design/troi_ctrl.sv
// ----------------------------------------------------------------------------
// troi_ctrl
// Sequencer: steps one pixel through multiply, convert, accumulate, optional
// mean division and output load.
// ----------------------------------------------------------------------------
module troi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  troi_pkg::t_dp_sts i_sts,
    output troi_pkg::t_dp_cmd o_cmd
);
    import troi_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_CONV;
            ST_CONV: n_state = ST_ACC;
            ST_ACC:  n_state = i_sts.last ? ST_DIV : ST_FIN;
            ST_DIV:  if (i_sts.div_done) n_state = ST_FIN;
            ST_FIN:  if (!i_sts.out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_CONV: o_cmd.conv = 1'b1;
            ST_ACC: begin
                o_cmd.acc       = 1'b1;
                o_cmd.div_start = i_sts.last;
            end
            ST_FIN:  o_cmd.load_out = !i_sts.out_busy;
            default: ;
        endcase
    end
endmodule

FILE: design/troi_checker.sv
// ----------------------------------------------------------------------------
// troi_checker
// Port-level checks of the thermal ROI statistics core.
// ----------------------------------------------------------------------------
`include "thermal_roi_statistics_core_assert.svh"

module troi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    `TROI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
    `TROI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result beat changed")
    `TROI_ASSERT_NEXT(a_one_at_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "pixel beat taken while one is in flight")
    `TROI_ASSERT(a_stats_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[127:24] == 104'd0, "statistics nonzero on a mid-frame beat")
endmodule

bind thermal_roi_statistics_core troi_checker u_troi_checker (.*);

FILE: tb/thermal_roi_statistics_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermal_roi_statistics_checker
// Snoops the config port and both stream channels, predicts each result beat
// from the accepted pixel beats and compares field by field.
// ----------------------------------------------------------------------------
module thermal_roi_statistics_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_data,
    input  logic         i_pix_valid,
    input  logic         i_pix_ready,
    input  logic [31:0]  i_pix_data,
    input  logic         i_pix_last,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [127:0] i_res_data,
    input  logic         i_res_last,
    output int           o_pending,
    output int           o_failures
);
    import troi_pkg::*;

    typedef struct packed {
        logic [23:0] temp;
        logic        done;
        logic [23:0] rmax;
        logic [23:0] rmin;
        logic [23:0] ravg;
        logic [24:0] rcnt;
    } t_stats;

    // configuration copy
    logic [1:0]  fmt;
    logic [12:0] fwidth;
    logic [23:0] iscale;
    logic signed [23:0] koff;
    logic signed [12:0] rx, ry;
    logic [13:0] rw, rh;

    // frame state
    int          col, row;
    int          run_max, run_min;
    longint      run_sum;
    int          run_cnt;

    t_stats      expected_q[$];
    int          failures;

    assign o_pending  = expected_q.size();
    assign o_failures = failures;

    function automatic longint sat24(longint v);
        if (v > longint'(T_MAX)) return longint'(T_MAX);
        if (v < longint'(T_MIN)) return longint'(T_MIN);
        return v;
    endfunction

    function automatic longint int16_to_q8(logic [31:0] w);
        longint acc;
        acc = longint'($signed(w[15:0])) * longint'(iscale)
            + longint'(koff) * 256 - longint'(KELVIN_Q16);
        return sat24((acc + 128) >>> 8);
    endfunction

    function automatic longint float_to_q8(logic [31:0] w);
        longint mag;
        longint man;
        int sh;
        int r;
        if (w[30:23] == 8'hFF) begin
            if (w[22:0] != 0) return 0;
            return w[31] ? longint'(T_MIN) : longint'(T_MAX);
        end
        if (w[30:23] == 8'h00) return 0;
        man = longint'({1'b1, w[22:0]});
        sh  = int'(w[30:23]) - 142;
        if (sh >= 24) begin
            mag = 64'd1 << 40;
        end else if (sh >= 0) begin
            mag = man << sh;
        end else begin
            r = -sh;
            if (r > 25) mag = 0;
            else mag = (man + (longint'(1) << (r - 1))) >> r;
        end
        return sat24(w[31] ? -mag : mag);
    endfunction

    task automatic clear_frame();
        col = 0;
        row = 0;
        run_max = int'(T_MIN);
        run_min = int'(T_MAX);
        run_sum = 0;
        run_cnt = 0;
    endtask

    task automatic predict_pixel(logic [31:0] w, logic last);
        t_stats e;
        longint t;
        bit     ok;
        int     width, xs, xe, ys, ye;
        longint avg;
        width = int'(fwidth);
        if (width == 0) width = 1;
        if (width > DEF_MAX_WIDTH) width = DEF_MAX_WIDTH;
        t  = 0;
        ok = 1'b0;
        if (fmt == FMT_INT16) begin
            t = int16_to_q8(w);
            ok = 1'b1;
        end else if (fmt == FMT_FLOAT) begin
            t = float_to_q8(w);
            ok = 1'b1;
        end
        xs = (rx < 0) ? 0 : int'(rx);
        xe = int'(rx) + int'(rw);
        if (xe > width) xe = width;
        ys = (ry < 0) ? 0 : int'(ry);
        ye = int'(ry) + int'(rh);
        if (ok && col >= xs && col < xe && row >= ys && row < ye
            && run_cnt < (1 << 24)) begin
            if (t > run_max) run_max = int'(t);
            if (t < run_min) run_min = int'(t);
            run_sum += t;
            run_cnt++;
        end
        if (col + 1 >= width) begin
            col = 0;
            if (row < int'(ROW_CAP)) row++;
        end else begin
            col++;
        end
        e = '0;
        e.temp = t[23:0];
        if (last) begin
            avg = (run_cnt > 0) ? run_sum / longint'(run_cnt) : 0;
            avg = sat24(avg);
            e.done = 1'b1;
            e.rmax = run_max[23:0];
            e.rmin = run_min[23:0];
            e.ravg = avg[23:0];
            e.rcnt = run_cnt[24:0];
            clear_frame();
        end
        expected_q.insert(expected_q.size(), e);
    endtask

    task automatic report(string what, logic [24:0] got, logic [24:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        failures++;
    endtask

    task automatic compare_result();
        t_stats e;
        if (expected_q.size() == 0) begin
            report("unexpected beat", i_res_data[24:0], '0);
            return;
        end
        e = expected_q.pop_front();
        if (i_res_data[23:0] !== e.temp)
            report("temperature", 25'(i_res_data[23:0]), 25'(e.temp));
        if (i_res_last !== e.done)
            report("frame_done", 25'(i_res_last), 25'(e.done));
        if (i_res_data[47:24] !== e.rmax)
            report("roi_max", 25'(i_res_data[47:24]), 25'(e.rmax));
        if (i_res_data[71:48] !== e.rmin)
            report("roi_min", 25'(i_res_data[71:48]), 25'(e.rmin));
        if (i_res_data[95:72] !== e.ravg)
            report("roi_average", 25'(i_res_data[95:72]), 25'(e.ravg));
        if (i_res_data[120:96] !== e.rcnt)
            report("roi_count", i_res_data[120:96], e.rcnt);
        if (i_res_data[127:121] !== '0)
            report("pad", 25'(i_res_data[127:121]), '0);
    endtask

    initial failures = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt    = FMT_INT16;
            fwidth = 13'd640;
            iscale = 24'd65536;
            koff   = '0;
            rx     = '0;
            ry     = '0;
            rw     = 14'd8192;
            rh     = 14'd8192;
            clear_frame();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FORMAT:  fmt    = i_cfg_data[1:0];
                    CFG_FWIDTH:  fwidth = i_cfg_data[12:0];
                    CFG_ISCALE:  iscale = i_cfg_data;
                    CFG_KOFFSET: koff   = i_cfg_data;
                    CFG_ROI_X:   rx     = i_cfg_data[12:0];
                    CFG_ROI_Y:   ry     = i_cfg_data[12:0];
                    CFG_ROI_W:   rw     = i_cfg_data[13:0];
                    CFG_ROI_H:   rh     = i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pix_data, i_pix_last);
            if (i_res_valid && i_res_ready) compare_result();
        end
    end

endmodule

FILE: tb/tb_thermal_roi_statistics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermal_roi_statistics_core
// Drives pixel frames in int16, float and invalid formats across many region
// and scaling settings with random idling on both sides; the checker judges.
// ----------------------------------------------------------------------------
module tb_thermal_roi_statistics_core;
    import troi_pkg::*;

    localparam int LIMIT     = 600000;
    localparam int SETTLE    = 80;
    localparam int RAND_PIX  = 1550;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [23:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;

    int           pending, failures;
    int           cycles;
    int           src_idle_pct, snk_stall_pct;
    int           pix_sent, frames_sent;
    logic [1:0]   cur_fmt;

    thermal_roi_statistics_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    thermal_roi_statistics_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_pix_valid(s_axis_tvalid), .i_pix_ready(s_axis_tready),
        .i_pix_data(s_axis_tdata), .i_pix_last(s_axis_tlast),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_last(m_axis_tlast),
        .o_pending(pending), .o_failures(failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == CFG_FORMAT) cur_fmt = val[1:0];
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drain all results, then let the bench settle
    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_pixel(logic [31:0] w, logic last);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < src_idle_pct) s_axis_tvalid <= 1'b0;
            else break;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pix_sent++;
        if (last) frames_sent++;
    endtask

    task automatic stop_pixels();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        int k;
        w = $urandom;
        k = $urandom_range(99);
        if (cur_fmt == FMT_FLOAT) begin
            if (k < 75) w[30:23] = 8'($urandom_range(150, 112));
            else if (k < 80) w[30:23] = 8'hFF;
            else if (k < 85) w[30:23] = 8'h00;
            else if (k < 90) w[30:23] = 8'($urandom_range(254, 151));
        end else if (k < 10) begin
            w[15:0] = (k < 5) ? 16'h8000 : 16'h7FFF;
        end
        return w;
    endfunction

    task automatic random_config(int p);
        logic [23:0] v;
        v = ($urandom_range(9) < 7) ? 24'($urandom_range(1)) : 24'($urandom_range(3));
        write_reg(CFG_FORMAT, v);
        if (p == 1)      v = 24'd4096;
        else if (p == 2) v = 24'd8191;
        else if (p == 3) v = 24'd0;
        else             v = 24'($urandom_range(9, 1));
        write_reg(CFG_FWIDTH, v);
        if (p == 1)      v = 24'hFFFFFF;
        else if (p == 2) v = 24'h000000;
        else             v = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(131072));
        write_reg(CFG_ISCALE, v);
        if (p == 1)      v = 24'h7FFFFF;
        else if (p == 2) v = 24'h800000;
        else             v = 24'($urandom);
        write_reg(CFG_KOFFSET, v);
        if (p == 1)      v = 24'h1000;          // -4096
        else if (p == 2) v = 24'h0FFF;          // 4095
        else             v = 24'(13'($signed($urandom_range(9)) - 3));
        write_reg(CFG_ROI_X, v);
        if (p == 1)      v = 24'h1000;
        else if (p == 2) v = 24'h0FFF;
        else             v = 24'(13'($signed($urandom_range(7)) - 2));
        write_reg(CFG_ROI_Y, v);
        if (p == 1)      v = 24'd8192;
        else if (p == 2) v = 24'd0;
        else             v = 24'($urandom_range(10));
        write_reg(CFG_ROI_W, v);
        if (p == 1 || p == 4) v = 24'd8192;
        else if (p == 2) v = 24'd0;
        else             v = 24'($urandom_range(8));
        write_reg(CFG_ROI_H, v);
        end_writes();
    endtask

    initial begin
        int p, n, len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        pix_sent      = 0;
        frames_sent   = 0;
        cur_fmt       = FMT_INT16;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: int16 extremes
        send_pixel(32'h0000_8000, 1'b0);
        send_pixel(32'h0000_7FFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        stop_pixels();
        wait_drained();
        // float specials: NaN, infinities, -0, subnormal, rounding tie, huge
        write_reg(CFG_FORMAT, 24'(FMT_FLOAT));
        write_reg(CFG_FWIDTH, 24'd3);
        end_writes();
        send_pixel(32'h7FC0_0001, 1'b0);
        send_pixel(32'h7F80_0000, 1'b0);
        send_pixel(32'hFF80_0000, 1'b0);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h3B00_0000, 1'b0);
        send_pixel(32'hBB00_0000, 1'b0);
        send_pixel(32'h3FC0_0000, 1'b0);
        send_pixel(32'h7F00_0000, 1'b0);
        send_pixel(32'hFF00_0000, 1'b1);
        stop_pixels();
        wait_drained();
        // invalid format, then empty region
        write_reg(CFG_FORMAT, 24'd2);
        end_writes();
        send_pixel(32'h4200_0000, 1'b0);
        send_pixel(32'h0000_1234, 1'b1);
        stop_pixels();
        wait_drained();
        write_reg(CFG_FORMAT, 24'(FMT_INT16));
        write_reg(CFG_ROI_W, 24'd0);
        end_writes();
        send_pixel(32'h0000_0100, 1'b0);
        send_pixel(32'h0000_0200, 1'b1);
        stop_pixels();
        wait_drained();

        p = 0;
        n = 0;
        while (n < RAND_PIX) begin
            random_config(p);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 32; snk_stall_pct = 32; end
            endcase
            repeat (4) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(90, 40) : $urandom_range(30, 1);
                for (int i = 0; i < len; i++) send_pixel(rand_word(), i == len - 1);
                n += len;
            end
            stop_pixels();
            wait_drained();
            p++;
        end

        $display("covered %0d pixels in %0d frames over %0d settings", pix_sent,
                 frames_sent, p);
        if (failures == 0) $display("tb: success");
        else               $display("tb: failure");
        $finish;
    end

endmodule
